// ----- sv/i2cms_pkg.sv -----
// Shared types, codes and constants of the I2C master transfer sequencer.
`default_nettype none

package i2cms_pkg;

   localparam int TX_DEPTH_DEF = 256;

   // Reciprocal scaling used to fold the store index into the store depth.
   localparam int RECIP_SHIFT = 16;
   localparam int QPROD_W     = 25;
   localparam int MOD_W       = 13;

   // Transaction kinds on the request channel.
   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_EVENT = 2'd2;

   // Control flag bits.
   localparam logic [3:0] FL_NONE = 4'h0;
   localparam logic [3:0] FL_ACK  = 4'h1;
   localparam logic [3:0] FL_INT  = 4'h2;
   localparam logic [3:0] FL_STO  = 4'h4;
   localparam logic [3:0] FL_STA  = 4'h8;
   localparam logic [3:0] FL_ALL  = 4'hF;

   // Bus status codes.
   localparam logic [7:0] SC_MASK        = 8'hF8;
   localparam logic [7:0] SC_STEP        = 8'h08;
   localparam logic [7:0] SC_BUS_ERROR   = 8'h00;
   localparam logic [7:0] SC_START       = 8'h08;
   localparam logic [7:0] SC_RSTART      = 8'h10;
   localparam logic [7:0] SC_TX_ADDR_ACK = 8'h18;
   localparam logic [7:0] SC_TX_ADDR_NAK = 8'h20;
   localparam logic [7:0] SC_TX_DATA_ACK = 8'h28;
   localparam logic [7:0] SC_TX_DATA_NAK = 8'h30;
   localparam logic [7:0] SC_ARB_LOST    = 8'h38;
   localparam logic [7:0] SC_RX_ADDR_ACK = 8'h40;
   localparam logic [7:0] SC_RX_ADDR_NAK = 8'h48;
   localparam logic [7:0] SC_RX_DATA_ACK = 8'h50;
   localparam logic [7:0] SC_RX_DATA_NAK = 8'h58;

   // Transfer status codes as reported on the result channel.
   localparam logic [2:0] XC_START    = 3'd0;
   localparam logic [2:0] XC_BUSY     = 3'd1;
   localparam logic [2:0] XC_DONE     = 3'd2;
   localparam logic [2:0] XC_NAK      = 3'd3;
   localparam logic [2:0] XC_ARB_LOST = 3'd4;
   localparam logic [2:0] XC_BUS_ERR  = 3'd5;

   typedef enum logic [5:0] {
      XS_START    = 6'b000001,
      XS_BUSY     = 6'b000010,
      XS_DONE     = 6'b000100,
      XS_NAK      = 6'b001000,
      XS_ARB_LOST = 6'b010000,
      XS_BUS_ERR  = 6'b100000
   } xfer_state_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [6:0]  slave_addr;
      logic [8:0]  tx_len;
      logic [15:0] rx_len;
      logic        ignore_nak;
      logic [7:0]  tx_index;
      logic [7:0]  tx_quot;
      logic [7:0]  tx_byte;
      logic [7:0]  status_code;
      logic [7:0]  bus_data;
   } req_item_type;

   typedef struct packed {
      logic [3:0] set_flags;
      logic [3:0] clear_flags;
      logic       drive_valid;
      logic [7:0] drive_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic [2:0] xfer_status;
      logic       finished;
   } rsp_item_type;

   typedef struct packed {
      logic       wr_en;
      logic [7:0] wr_index;
      logic [7:0] wr_quot;
      logic [7:0] wr_data;
   } store_ctl_type;

   function automatic logic [2:0] xs_code(input xfer_state_type st);
      logic [2:0] code;
      case (st)
         XS_START:    code = XC_START;
         XS_BUSY:     code = XC_BUSY;
         XS_DONE:     code = XC_DONE;
         XS_NAK:      code = XC_NAK;
         XS_ARB_LOST: code = XC_ARB_LOST;
         XS_BUS_ERR:  code = XC_BUS_ERR;
         default:     code = XC_START;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- sv/i2cms_tx_store.sv -----
// Transmit byte store with a prefetched read of the current transmit position.
`default_nettype none

module i2cms_tx_store #(
   parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF,
   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
   input  wire logic                     clock,
   input  wire i2cms_pkg::store_ctl_type ctl,
   input  wire logic [AW-1:0]            rd_addr,
   output logic [7:0]                    rd_byte
);
   import i2cms_pkg::*;

   localparam logic [MOD_W-1:0] DEPTH_W = MOD_W'(TX_DEPTH);

   logic [7:0]       mem [TX_DEPTH];
   logic [7:0]       rd_ff;
   logic [MOD_W-1:0] prod;
   logic [MOD_W-1:0] rem;
   logic [MOD_W-1:0] rem_fix;
   logic [AW-1:0]    wr_addr;

   // Index modulo depth: the quotient estimate is low by at most one.
   always_comb begin
      prod    = MOD_W'(ctl.wr_quot) * DEPTH_W;
      rem     = MOD_W'(ctl.wr_index) - prod;
      rem_fix = (rem >= DEPTH_W) ? (rem - DEPTH_W) : rem;
      wr_addr = rem_fix[AW-1:0];
   end

   // Read the next position every cycle; forward a same-cycle write.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      if (ctl.wr_en && (wr_addr == rd_addr)) begin
         rd_ff <= ctl.wr_data;
      end else begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rd_byte = rd_ff;

endmodule

`default_nettype wire

// ----- sv/i2cms_core.sv -----
// Transfer state registers and the per-transaction status code decode.
`default_nettype none

module i2cms_core #(
   parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF,
   localparam int AW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      proc,
   input  wire i2cms_pkg::req_item_type   item,
   input  wire logic [7:0]                tx_rd_byte,
   output i2cms_pkg::store_ctl_type       store_ctl,
   output logic [AW-1:0]                  rd_addr,
   output i2cms_pkg::rsp_item_type        res
);
   import i2cms_pkg::*;

   localparam logic [AW-1:0] POS_LAST = AW'(TX_DEPTH - 1);

   logic [AW-1:0]  pos_ff, pos_in;
   logic [8:0]     txrem_ff, txrem_in;
   logic [15:0]    rxrem_ff, rxrem_in;
   logic [6:0]     addr_ff, addr_in;
   logic           mask_ff, mask_in;
   logic           loaded_ff, loaded_in;
   xfer_state_type st_ff, st_in;

   logic [7:0] code;
   logic [3:0] cclr;
   logic [3:0] cset;

   always_comb begin
      pos_in    = pos_ff;
      txrem_in  = txrem_ff;
      rxrem_in  = rxrem_ff;
      addr_in   = addr_ff;
      mask_in   = mask_ff;
      loaded_in = loaded_ff;
      st_in     = st_ff;
      cclr      = FL_NONE;
      cset      = FL_NONE;
      res       = '0;
      store_ctl.wr_en    = 1'b0;
      store_ctl.wr_index = item.tx_index;
      store_ctl.wr_quot  = item.tx_quot;
      store_ctl.wr_data  = item.tx_byte;

      code = item.status_code & SC_MASK;
      if (mask_ff && ((code == SC_TX_ADDR_NAK) || (code == SC_TX_DATA_NAK) ||
                      (code == SC_RX_ADDR_NAK))) begin
         code = code - SC_STEP;
      end

      case (item.kind)
         REQ_LOAD: begin
            addr_in   = item.slave_addr;
            txrem_in  = item.tx_len;
            rxrem_in  = item.rx_len;
            mask_in   = item.ignore_nak;
            pos_in    = '0;
            st_in     = XS_START;
            loaded_in = 1'b1;
            cset      = FL_STA;
            cclr      = FL_ACK | FL_INT | FL_STO;
         end
         REQ_WRITE: begin
            store_ctl.wr_en = proc;
         end
         REQ_EVENT: begin
            if (!loaded_ff) begin
               cclr = FL_INT | FL_ACK | FL_STA;
            end else begin
               cclr = FL_ALL;
               case (code)
                  SC_START, SC_RSTART: begin
                     if ((code == SC_START) && (st_ff == XS_START)) begin
                        st_in = XS_BUSY;
                     end
                     res.drive_valid = 1'b1;
                     res.drive_byte  = {addr_ff, (txrem_ff == 9'd0)};
                  end
                  SC_TX_ADDR_ACK, SC_TX_DATA_ACK: begin
                     if (txrem_ff == 9'd0) begin
                        // Repeated start into the read phase, or stop.
                        cclr = (rxrem_ff != 16'd0) ? (cclr & ~FL_STA) : (cclr & ~FL_STO);
                     end else begin
                        res.drive_valid = 1'b1;
                        res.drive_byte  = tx_rd_byte;
                        pos_in   = (pos_ff == POS_LAST) ? '0 : (pos_ff + AW'(1));
                        txrem_in = txrem_ff - 9'd1;
                     end
                  end
                  SC_RX_DATA_NAK, SC_RX_DATA_ACK, SC_RX_ADDR_ACK: begin
                     if (code == SC_RX_DATA_NAK) begin
                        cclr = cclr & ~FL_STO;
                     end
                     if ((code != SC_RX_ADDR_ACK) && (rxrem_ff != 16'd0)) begin
                        res.rx_valid = 1'b1;
                        res.rx_byte  = item.bus_data;
                        rxrem_in     = rxrem_ff - 16'd1;
                     end
                     if (rxrem_in > 16'd1) begin
                        cclr = cclr & ~FL_ACK;
                     end
                  end
                  SC_TX_ADDR_NAK, SC_TX_DATA_NAK, SC_RX_ADDR_NAK: begin
                     st_in = XS_NAK;
                     cclr  = cclr & ~FL_STO;
                  end
                  SC_ARB_LOST: begin
                     st_in = XS_ARB_LOST;
                  end
                  SC_BUS_ERROR: begin
                     st_in = XS_BUS_ERR;
                     cclr  = cclr & ~FL_STO;
                  end
                  default: begin
                  end
               endcase
               cset = ~cclr;
               if (((cclr & FL_STO) == FL_NONE) || (st_in == XS_ARB_LOST)) begin
                  if (st_in == XS_BUSY) begin
                     st_in = XS_DONE;
                  end
                  res.finished = 1'b1;
                  loaded_in    = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      res.set_flags   = cset;
      res.clear_flags = cclr;
      res.xfer_status = xs_code(st_in);
   end

   // Keep the prefetch address on the position the next transaction will see.
   assign rd_addr = proc ? pos_in : pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         txrem_ff  <= '0;
         rxrem_ff  <= '0;
         addr_ff   <= '0;
         mask_ff   <= 1'b0;
         loaded_ff <= 1'b0;
         st_ff     <= XS_START;
      end else if (proc) begin
         pos_ff    <= pos_in;
         txrem_ff  <= txrem_in;
         rxrem_ff  <= rxrem_in;
         addr_ff   <= addr_in;
         mask_ff   <= mask_in;
         loaded_ff <= loaded_in;
         st_ff     <= st_in;
      end
   end

   a_load_arms: assert property (@(posedge clock) disable iff (reset)
      proc && (item.kind == REQ_LOAD) |=> loaded_ff && (st_ff == XS_START))
      else $error("load did not arm the transfer");

   a_finish_unloads: assert property (@(posedge clock) disable iff (reset)
      proc && res.finished |=> !loaded_ff)
      else $error("finished transfer still loaded");

   a_drive_rx_excl: assert property (@(posedge clock) disable iff (reset)
      proc |-> !(res.drive_valid && res.rx_valid))
      else $error("drive and receive in one transaction");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("transmit position beyond store depth");

endmodule

`default_nettype wire

// ----- sv/i2c_master_transfer_sequencer.sv -----
// Top level of the I2C master transfer sequencer: handshake, item and result registers.
//
// A transaction is taken into an input register, decoded combinationally against the
// transfer state and written to a result register, so one transaction is accepted per cycle
// while the result side keeps up; a stalled result holds one transaction in each register.
// The result is valid once the result register has captured it and stays until taken.
// The transmit store is a TX_DEPTH by 8 memory
// with one write port and one registered read that always prefetches the byte at the current
// transmit position. Byte writes land at tx_index modulo TX_DEPTH. Store entries start
// undefined and need no clearing after reset.
`default_nettype none

module i2c_master_transfer_sequencer #(
   parameter int TX_DEPTH = i2cms_pkg::TX_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [6:0]  req_slave_addr,
   input  wire logic [8:0]  req_tx_len,
   input  wire logic [15:0] req_rx_len,
   input  wire logic        req_ignore_nak,
   input  wire logic [7:0]  req_tx_index,
   input  wire logic [7:0]  req_tx_byte,
   input  wire logic [7:0]  req_status_code,
   input  wire logic [7:0]  req_bus_data,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [3:0]       rsp_set_flags,
   output logic [3:0]       rsp_clear_flags,
   output logic             rsp_drive_valid,
   output logic [7:0]       rsp_drive_byte,
   output logic             rsp_rx_valid,
   output logic [7:0]       rsp_rx_byte,
   output logic [2:0]       rsp_xfer_status,
   output logic             rsp_finished
);
   import i2cms_pkg::*;

   localparam int AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int RECIP = (1 << RECIP_SHIFT) / TX_DEPTH;

   logic          stg_valid_ff, stg_valid_in;
   req_item_type  stg_ff, stg_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_ff;
   rsp_item_type  core_res;
   store_ctl_type store_ctl;
   logic [AW-1:0] rd_addr;
   logic [7:0]    tx_rd_byte;
   logic [QPROD_W-1:0] qprod;
   logic          req_fire;
   logic          adv;
   logic          proc;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = !stg_valid_ff || adv;
   assign req_fire  = req_valid && req_ready;
   assign proc      = stg_valid_ff && adv;

   // Quotient estimate of the store index, finished in the store after the register.
   assign qprod = QPROD_W'(req_tx_index) * QPROD_W'(RECIP);

   always_comb begin
      stg_in.kind        = req_type;
      stg_in.slave_addr  = req_slave_addr;
      stg_in.tx_len      = req_tx_len;
      stg_in.rx_len      = req_rx_len;
      stg_in.ignore_nak  = req_ignore_nak;
      stg_in.tx_index    = req_tx_index;
      stg_in.tx_quot     = qprod[RECIP_SHIFT +: 8];
      stg_in.tx_byte     = req_tx_byte;
      stg_in.status_code = req_status_code;
      stg_in.bus_data    = req_bus_data;
   end

   assign stg_valid_in = req_fire || (stg_valid_ff && !adv);
   assign out_valid_in = proc || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_ff <= stg_in;
      end
      if (proc) begin
         out_ff <= core_res;
      end
   end

   i2cms_core #(.TX_DEPTH(TX_DEPTH)) u_core (
      .clock      (clock),
      .reset      (reset),
      .proc       (proc),
      .item       (stg_ff),
      .tx_rd_byte (tx_rd_byte),
      .store_ctl  (store_ctl),
      .rd_addr    (rd_addr),
      .res        (core_res)
   );

   i2cms_tx_store #(.TX_DEPTH(TX_DEPTH)) u_tx_store (
      .clock   (clock),
      .ctl     (store_ctl),
      .rd_addr (rd_addr),
      .rd_byte (tx_rd_byte)
   );

   assign rsp_valid       = out_valid_ff;
   assign rsp_set_flags   = out_ff.set_flags;
   assign rsp_clear_flags = out_ff.clear_flags;
   assign rsp_drive_valid = out_ff.drive_valid;
   assign rsp_drive_byte  = out_ff.drive_byte;
   assign rsp_rx_valid    = out_ff.rx_valid;
   assign rsp_rx_byte     = out_ff.rx_byte;
   assign rsp_xfer_status = out_ff.xfer_status;
   assign rsp_finished    = out_ff.finished;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff && !proc |=> stg_valid_ff)
      else $error("staged transaction dropped");

   a_flags_disjoint: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_ff.set_flags & out_ff.clear_flags) == FL_NONE))
      else $error("flag both set and cleared");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      proc |=> out_valid_ff)
      else $error("processed transaction produced no result");

endmodule

`default_nettype wire
